[rtl/ntcat_pkg.sv]
package ntcat_pkg;

   localparam int ADC_W   = 12;
   localparam int TEMP_W  = 12;
   localparam int PROD_W  = 26;
   localparam int DIV_W   = 24;
   localparam int COEF_W  = 20;
   localparam int P1_W    = 30;
   localparam int POLY_W  = 33;
   localparam int TQ_W    = POLY_W - 12;
   localparam int POLY_STAGES = 9;

   localparam logic [ADC_W-1:0] ADC_MAX   = 12'd4095;
   localparam logic [ADC_W-1:0] ADC_AT_25 = 12'd2786;

   localparam logic [17:0] HI_K3 = 18'd134764;
   localparam logic [17:0] LO_K3 = 18'd9504;
   localparam logic signed [COEF_W-1:0] HI_K2 = 20'sd56037;
   localparam logic signed [COEF_W-1:0] LO_K2 = 20'sd6730;
   localparam logic signed [COEF_W-1:0] HI_K1 = 20'sd8711;
   localparam logic signed [COEF_W-1:0] LO_K1 = 20'sd1677;
   localparam logic signed [COEF_W-1:0] HI_K0 = 20'sd700;
   localparam logic signed [COEF_W-1:0] LO_K0 = 20'sd876;

   localparam logic signed [TQ_W:0] TEMP_AT_25 = 22'sd250;
   localparam logic signed [TQ_W:0] TEMP_MIN   = -22'sd300;
   localparam logic signed [TQ_W:0] TEMP_MAX   = 22'sd1100;

   localparam logic [2:0] CSR_PULL_UP      = 3'd0;
   localparam logic [2:0] CSR_CAL_IN_LOW   = 3'd1;
   localparam logic [2:0] CSR_CAL_IN_HIGH  = 3'd2;
   localparam logic [2:0] CSR_CAL_OUT_LOW  = 3'd3;
   localparam logic [2:0] CSR_CAL_OUT_HIGH = 3'd4;

   typedef struct packed {
      logic              neg;
      logic              bypass;
      logic [ADC_W-1:0]  raw;
      logic [DIV_W-1:0]  mag;
   } div_req_type;

   typedef struct packed {
      logic              neg;
      logic              bypass;
      logic [ADC_W-1:0]  raw;
      logic [DIV_W-1:0]  quo;
   } div_rsp_type;

   // Divide by 4096 with truncation toward zero.
   function automatic logic signed [TQ_W-1:0] trunc_div(input logic signed [POLY_W-1:0] p);
      logic signed [POLY_W-1:0] b;
      b = p + (p[POLY_W-1] ? 33'sd4095 : 33'sd0);
      return b[POLY_W-1:12];
   endfunction

endpackage

[rtl/ntcat_div.sv]
module ntcat_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ntcat_pkg::ADC_W-1:0]         divisor,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  ntcat_pkg::div_req_type              in_data,
   output logic                                out_valid,
   input  logic                                out_ready,
   output ntcat_pkg::div_rsp_type              out_data
);

   localparam int N = ntcat_pkg::DIV_W;

   typedef struct packed {
      logic                            neg;
      logic                            bypass;
      logic [ntcat_pkg::ADC_W-1:0]     raw;
      logic [ntcat_pkg::ADC_W-1:0]     rem;
      logic [ntcat_pkg::DIV_W-1:0]     nq;
   } stage_type;

   stage_type stage_ff [N];
   logic      valid_ff [N];
   logic      adv      [N];
   stage_type head;

   assign head = '{neg: in_data.neg, bypass: in_data.bypass, raw: in_data.raw,
                   rem: '0, nq: in_data.mag};

   for (genvar s = 0; s < N; s++) begin : g_stage
      stage_type                     src;
      stage_type                     stage_in;
      logic                          src_valid;
      logic [ntcat_pkg::ADC_W:0]     trial;
      logic [ntcat_pkg::ADC_W:0]     diff;
      logic                          ge;

      if (s == 0) begin : g_first
         assign src       = head;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = stage_ff[s-1];
         assign src_valid = valid_ff[s-1];
      end

      if (s == N - 1) begin : g_last
         assign adv[s] = !valid_ff[s] || out_ready;
      end else begin : g_mid
         assign adv[s] = !valid_ff[s] || adv[s+1];
      end

      // one quotient bit per stage: shift in the next numerator bit, try to subtract
      assign trial = {src.rem, src.nq[N-1]};
      assign diff  = trial - {1'b0, divisor};
      assign ge    = trial >= {1'b0, divisor};

      always_comb begin
         stage_in     = src;
         stage_in.rem = ge ? diff[ntcat_pkg::ADC_W-1:0] : trial[ntcat_pkg::ADC_W-1:0];
         stage_in.nq  = {src.nq[N-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            stage_ff[s] <= stage_in;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[N-1];
   assign out_data  = '{neg: stage_ff[N-1].neg, bypass: stage_ff[N-1].bypass,
                        raw: stage_ff[N-1].raw, quo: stage_ff[N-1].nq};

endmodule

[rtl/ntcat_poly.sv]
module ntcat_poly (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [ntcat_pkg::ADC_W-1:0]         adc,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [ntcat_pkg::TEMP_W-1:0] temp
);

   localparam int N = ntcat_pkg::POLY_STAGES;

   logic valid_ff [N];
   logic adv      [N];

   logic                                  hi_ff [8];
   logic [ntcat_pkg::ADC_W-1:0]           x_ff  [7];
   logic [ntcat_pkg::P1_W-1:0]            p1_ff;
   logic signed [ntcat_pkg::COEF_W-1:0]   s1_ff, s2_ff, s3_ff;
   logic signed [ntcat_pkg::POLY_W-1:0]   p2_ff, p3_ff, p4_ff;
   logic signed [ntcat_pkg::TEMP_W-1:0]   temp_ff;

   logic                                  hi_in;
   logic [ntcat_pkg::ADC_W-1:0]           x_in;
   logic signed [ntcat_pkg::COEF_W-1:0]   s1_in;
   logic signed [ntcat_pkg::TQ_W-1:0]     s2_sum, s3_sum, tq;
   logic signed [ntcat_pkg::TQ_W:0]       t_full;
   logic signed [ntcat_pkg::TEMP_W-1:0]   temp_in;

   for (genvar k = 0; k < N; k++) begin : g_ctl
      if (k == N - 1) begin : g_last
         assign adv[k] = !valid_ff[k] || out_ready;
      end else begin : g_mid
         assign adv[k] = !valid_ff[k] || adv[k+1];
      end
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (adv[k]) begin
               valid_ff[k] <= in_valid;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // carry branch select and offset along with the data
   for (genvar k = 1; k < 8; k++) begin : g_hi
      always_ff @(posedge clock) begin
         if (adv[k]) begin
            hi_ff[k] <= hi_ff[k-1];
         end
      end
   end

   for (genvar k = 1; k < 7; k++) begin : g_x
      always_ff @(posedge clock) begin
         if (adv[k]) begin
            x_ff[k] <= x_ff[k-1];
         end
      end
   end

   assign hi_in = adc >= ntcat_pkg::ADC_AT_25;
   assign x_in  = hi_in ? adc - ntcat_pkg::ADC_AT_25 : ntcat_pkg::ADC_AT_25 - adc;

   assign s1_in  = $signed({2'b00, p1_ff[ntcat_pkg::P1_W-1:12]})
                   - (hi_ff[1] ? ntcat_pkg::HI_K2 : ntcat_pkg::LO_K2);
   assign s2_sum = ntcat_pkg::trunc_div(p2_ff)
                   + ntcat_pkg::TQ_W'(hi_ff[3] ? ntcat_pkg::HI_K1 : ntcat_pkg::LO_K1);
   assign s3_sum = ntcat_pkg::trunc_div(p3_ff)
                   + ntcat_pkg::TQ_W'(hi_ff[5] ? ntcat_pkg::HI_K0 : ntcat_pkg::LO_K0);
   assign tq     = ntcat_pkg::trunc_div(p4_ff);
   assign t_full = hi_ff[7] ? ntcat_pkg::TEMP_AT_25 - (ntcat_pkg::TQ_W+1)'(tq)
                            : ntcat_pkg::TEMP_AT_25 + (ntcat_pkg::TQ_W+1)'(tq);

   always_comb begin
      if (t_full < ntcat_pkg::TEMP_MIN) begin
         temp_in = ntcat_pkg::TEMP_MIN[ntcat_pkg::TEMP_W-1:0];
      end else if (t_full > ntcat_pkg::TEMP_MAX) begin
         temp_in = ntcat_pkg::TEMP_MAX[ntcat_pkg::TEMP_W-1:0];
      end else begin
         temp_in = t_full[ntcat_pkg::TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         hi_ff[0] <= hi_in;
         x_ff[0]  <= x_in;
      end
      if (adv[1]) begin
         p1_ff <= ntcat_pkg::P1_W'(hi_ff[0] ? ntcat_pkg::HI_K3 : ntcat_pkg::LO_K3)
                  * ntcat_pkg::P1_W'(x_ff[0]);
      end
      if (adv[2]) begin
         s1_ff <= s1_in;
      end
      if (adv[3]) begin
         p2_ff <= ntcat_pkg::POLY_W'(s1_ff) * ntcat_pkg::POLY_W'($signed({1'b0, x_ff[2]}));
      end
      if (adv[4]) begin
         s2_ff <= s2_sum[ntcat_pkg::COEF_W-1:0];
      end
      if (adv[5]) begin
         p3_ff <= ntcat_pkg::POLY_W'(s2_ff) * ntcat_pkg::POLY_W'($signed({1'b0, x_ff[4]}));
      end
      if (adv[6]) begin
         s3_ff <= s3_sum[ntcat_pkg::COEF_W-1:0];
      end
      if (adv[7]) begin
         p4_ff <= ntcat_pkg::POLY_W'(s3_ff) * ntcat_pkg::POLY_W'($signed({1'b0, x_ff[6]}));
      end
      if (adv[8]) begin
         temp_ff <= temp_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[N-1];
   assign temp      = temp_ff;

endmodule

[rtl/ntc_adc_to_temperature.sv]
// Channel   Ports                        Payload
// ------    ---------------------------  ----------------------------------------
// request   req_tvalid/tready/tdata      raw_adc, 12 bits unsigned
// response  rsp_tvalid/tready/tdata      temp_tenths, 12 bits signed, -300..1100
// config    csr_valid/ready/index/data   index 0..4, data up to 12 bits
//
// One sample enters per cycle while req_tready is high; each passes through 3 front
// stages (capture, multiply, magnitude), 24 stages of the one-bit-per-stage
// calibration divider, 1 clamp stage and 9 polynomial stages.
// Reset clears all valid bits and loads the default calibration registers.
// A held response stalls only the stages behind it; bubbles still drain forward.
module ntc_adc_to_temperature (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] raw_adc
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] temp_tenths
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam int AW = ntcat_pkg::ADC_W;

   logic          pull_up_ff;
   logic [AW-1:0] cal_in_low_ff, cal_in_high_ff, cal_out_low_ff, cal_out_high_ff;

   logic          v0_ff, v1_ff, v2_ff, v3_ff;
   logic          adv0, adv1, adv2, adv3;
   logic [AW-1:0] raw0_ff, raw1_ff;
   logic signed [ntcat_pkg::PROD_W-1:0] prod_ff, prod_in, prod_abs;
   logic signed [AW:0]                  diff, slope, span;
   logic [AW-1:0]                       divisor;
   ntcat_pkg::div_req_type              div_req_ff, div_req_in;
   ntcat_pkg::div_rsp_type              div_rsp;
   logic                                div_in_ready, div_out_valid;
   logic [AW-1:0]                       adj_ff, adj_in, cal_val;
   logic [ntcat_pkg::DIV_W:0]           up_sum;
   logic                                poly_in_ready;
   logic signed [ntcat_pkg::TEMP_W-1:0] temp;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pull_up_ff      <= 1'b1;
         cal_in_low_ff   <= '0;
         cal_in_high_ff  <= ntcat_pkg::ADC_MAX;
         cal_out_low_ff  <= '0;
         cal_out_high_ff <= ntcat_pkg::ADC_MAX;
      end else if (csr_valid) begin
         case (csr_index)
            ntcat_pkg::CSR_PULL_UP:      pull_up_ff      <= csr_data[0];
            ntcat_pkg::CSR_CAL_IN_LOW:   cal_in_low_ff   <= csr_data;
            ntcat_pkg::CSR_CAL_IN_HIGH:  cal_in_high_ff  <= csr_data;
            ntcat_pkg::CSR_CAL_OUT_LOW:  cal_out_low_ff  <= csr_data;
            ntcat_pkg::CSR_CAL_OUT_HIGH: cal_out_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // front stages
   assign adv2 = !v2_ff || div_in_ready;
   assign adv1 = !v1_ff || adv2;
   assign adv0 = !v0_ff || adv1;
   assign adv3 = !v3_ff || poly_in_ready;
   assign req_tready = adv0;

   assign diff    = $signed({1'b0, raw0_ff}) - $signed({1'b0, cal_in_low_ff});
   assign slope   = $signed({1'b0, cal_out_high_ff}) - $signed({1'b0, cal_out_low_ff});
   assign span    = $signed({1'b0, cal_in_high_ff}) - $signed({1'b0, cal_in_low_ff});
   assign prod_in = ntcat_pkg::PROD_W'(diff) * ntcat_pkg::PROD_W'(slope);
   assign divisor = span[AW] ? AW'(-span) : span[AW-1:0];

   assign prod_abs = prod_ff[ntcat_pkg::PROD_W-1] ? -prod_ff : prod_ff;

   always_comb begin
      div_req_in.neg    = prod_ff[ntcat_pkg::PROD_W-1] ^ span[AW];
      div_req_in.bypass = span == '0;
      div_req_in.raw    = raw1_ff;
      div_req_in.mag    = prod_abs[ntcat_pkg::DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv0) v0_ff <= req_tvalid;
         if (adv1) v1_ff <= v0_ff;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv0) begin
         raw0_ff <= req_tdata[AW-1:0];
      end
      if (adv1) begin
         prod_ff <= prod_in;
         raw1_ff <= raw0_ff;
      end
      if (adv2) begin
         div_req_ff <= div_req_in;
      end
      if (adv3) begin
         adj_ff <= adj_in;
      end
   end

   ntcat_div u_div (
      .clock     (clock),
      .reset     (reset),
      .divisor   (divisor),
      .in_valid  (v2_ff),
      .in_ready  (div_in_ready),
      .in_data   (div_req_ff),
      .out_valid (div_out_valid),
      .out_ready (adv3),
      .out_data  (div_rsp)
   );

   // add offset (or pass raw through for a zero input span), clamp to the ADC range, mirror for pull-down
   assign up_sum = {{(ntcat_pkg::DIV_W + 1 - AW){1'b0}}, cal_out_low_ff}
                   + {1'b0, div_rsp.quo};

   always_comb begin
      if (div_rsp.bypass) begin
         cal_val = div_rsp.raw;
      end else if (div_rsp.neg) begin
         if (div_rsp.quo > {{(ntcat_pkg::DIV_W - AW){1'b0}}, cal_out_low_ff}) begin
            cal_val = '0;
         end else begin
            cal_val = cal_out_low_ff - div_rsp.quo[AW-1:0];
         end
      end else if (up_sum > {{(ntcat_pkg::DIV_W + 1 - AW){1'b0}}, ntcat_pkg::ADC_MAX}) begin
         cal_val = ntcat_pkg::ADC_MAX;
      end else begin
         cal_val = up_sum[AW-1:0];
      end
      adj_in = pull_up_ff ? cal_val : ntcat_pkg::ADC_MAX - cal_val;
   end

   ntcat_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_ready  (poly_in_ready),
      .adc       (adj_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .temp      (temp)
   );

   assign rsp_tdata = {{(16 - ntcat_pkg::TEMP_W){1'b0}}, temp};

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v0_ff)
      else $error("request transfer did not load the capture stage");

   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v0_ff && v1_ff && v2_ff && !div_in_ready)
      else $error("front stages stalled while a bubble was present");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[11:0]) >= -12'sd300)
                     && ($signed(rsp_tdata[11:0]) <= 12'sd1100))
      else $error("temperature outside saturation range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("held response changed before its transfer");

endmodule
